[src/dad_pkg.sv]
// ----------------------------------------------------------------------------
// dad_pkg: shared types and calendar helpers for the date adder
// Field widths, controller and datapath command types, month tables.
// ----------------------------------------------------------------------------
package dad_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 21;
    localparam int STAT_W  = 2;

    // internal widths: remainder, signed day count, step index
    localparam int ACC_W = 22;
    localparam int N_W   = 24;
    localparam int K_W   = 3;

    // calendar constants
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_MAX  = MONTH_W'(12);
    localparam logic [N_W-1:0]     DAYS_LIMIT = N_W'(3652059);

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_F400,
        DP_F100,
        DP_FREM,
        DP_SUM,
        DP_BLOAD,
        DP_B400,
        DP_B100,
        DP_B4,
        DP_B1,
        DP_MONTH,
        DP_FINISH
    } t_dp_op;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_F400,
        S_F100,
        S_FREM,
        S_DAYCHK,
        S_RANGE,
        S_B400,
        S_B100,
        S_B4,
        S_B1,
        S_MON
    } t_state;

    // command from controller to datapath
    typedef struct packed {
        t_dp_op          op;
        logic [K_W-1:0]  k;
        t_status         status;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic basic_bad;
        logic day_bad;
        logic range_bad;
        logic month_done;
    } t_dp_stat;

    // leap year from the digits of (year - 1) in the 400/100/4/1 system
    function automatic logic leap_from_digits(input logic [1:0] q100,
                                              input logic [4:0] q4,
                                              input logic [1:0] q1);
        return (q1 == 2'd3) && ((q4 != 5'd24) || (q100 == 2'd3));
    endfunction

    // days in a month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the first of a month in a common year
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] days;
        unique case (m)
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

[src/dad_ctrl.sv]
// ----------------------------------------------------------------------------
// dad_ctrl: sequencing state machine for the date adder
// Steps the datapath through validation, date to day count, range check
// and day count back to date, one digit bit or month per cycle.
// ----------------------------------------------------------------------------
module dad_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  dad_pkg::t_dp_stat i_stat,
    output dad_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import dad_pkg::*;

    t_state         r_state, n_state;
    logic [K_W-1:0] r_k, n_k;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        o_cmd.op     = DP_NONE;
        o_cmd.k      = r_k;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.basic_bad) begin
                    o_cmd.op     = DP_FINISH;
                    o_cmd.status = ST_BAD_DATE;
                    n_state      = S_IDLE;
                end else begin
                    n_k     = K_W'(4);
                    n_state = S_F400;
                end
            end
            S_F400: begin
                o_cmd.op = DP_F400;
                if (r_k == '0) begin
                    n_k     = K_W'(1);
                    n_state = S_F100;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end
            S_F100: begin
                o_cmd.op = DP_F100;
                if (r_k == '0) begin
                    n_state = S_FREM;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end
            S_FREM: begin
                o_cmd.op = DP_FREM;
                n_state  = S_DAYCHK;
            end
            S_DAYCHK: begin
                if (i_stat.day_bad) begin
                    o_cmd.op     = DP_FINISH;
                    o_cmd.status = ST_BAD_DATE;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op = DP_SUM;
                    n_state  = S_RANGE;
                end
            end
            S_RANGE: begin
                if (i_stat.range_bad) begin
                    o_cmd.op     = DP_FINISH;
                    o_cmd.status = ST_RANGE;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op = DP_BLOAD;
                    n_k      = K_W'(4);
                    n_state  = S_B400;
                end
            end
            S_B400: begin
                o_cmd.op = DP_B400;
                if (r_k == '0) begin
                    n_k     = K_W'(1);
                    n_state = S_B100;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end
            S_B100: begin
                o_cmd.op = DP_B100;
                if (r_k == '0) begin
                    n_k     = K_W'(4);
                    n_state = S_B4;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end
            S_B4: begin
                o_cmd.op = DP_B4;
                if (r_k == '0) begin
                    n_k     = K_W'(1);
                    n_state = S_B1;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end
            S_B1: begin
                o_cmd.op = DP_B1;
                if (r_k == '0) begin
                    n_state = S_MON;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end
            S_MON: begin
                if (i_stat.month_done) begin
                    o_cmd.op     = DP_FINISH;
                    o_cmd.status = ST_OK;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op = DP_MONTH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[src/dad_datapath.sv]
// ----------------------------------------------------------------------------
// dad_datapath: registers and arithmetic of the date adder
// Restoring digit steps against shifted cycle lengths in both directions,
// month walk, range check and result registers.
// ----------------------------------------------------------------------------
module dad_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [dad_pkg::YEAR_W-1:0]   i_in_year,
    input  logic [dad_pkg::MONTH_W-1:0]  i_in_month,
    input  logic [dad_pkg::DAY_W-1:0]    i_in_day,
    input  logic [dad_pkg::OFF_W-1:0]    i_day_offset,
    input  dad_pkg::t_dp_cmd             i_cmd,
    output dad_pkg::t_dp_stat            o_stat,
    output logic                         o_valid,
    output logic [dad_pkg::YEAR_W-1:0]   o_out_year,
    output logic [dad_pkg::MONTH_W-1:0]  o_out_month,
    output logic [dad_pkg::DAY_W-1:0]    o_out_day,
    output logic [dad_pkg::STAT_W-1:0]   o_status
);
    import dad_pkg::*;

    // cycle lengths in days and years
    localparam logic [ACC_W-1:0]  C_DAYS_400 = ACC_W'(146097);
    localparam logic [ACC_W-1:0]  C_DAYS_100 = ACC_W'(36524);
    localparam logic [ACC_W-1:0]  C_DAYS_4   = ACC_W'(1461);
    localparam logic [ACC_W-1:0]  C_DAYS_1   = ACC_W'(365);
    localparam logic [ACC_W-1:0]  C_YRS_400  = ACC_W'(400);
    localparam logic [ACC_W-1:0]  C_YRS_100  = ACC_W'(100);
    localparam logic [YEAR_W-1:0] C_Y400     = YEAR_W'(400);
    localparam logic [YEAR_W-1:0] C_Y100     = YEAR_W'(100);
    localparam logic [YEAR_W-1:0] C_Y4       = YEAR_W'(4);
    localparam logic [YEAR_W-1:0] C_Y1       = YEAR_W'(1);

    // captured request
    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;
    logic [OFF_W-1:0]   r_off;

    // working registers
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [N_W-1:0]     r_n, n_n;
    logic [1:0]         r_q100, n_q100;
    logic [4:0]         r_q4, n_q4;
    logic [1:0]         r_q1, n_q1;
    logic [YEAR_W-1:0]  r_ry, n_ry;
    logic [MONTH_W-1:0] r_rm, n_rm;

    // result registers
    logic               r_valid, n_valid;
    logic [YEAR_W-1:0]  r_out_year, n_out_year;
    logic [MONTH_W-1:0] r_out_month, n_out_month;
    logic [DAY_W-1:0]   r_out_day, n_out_day;
    logic [STAT_W-1:0]  r_out_status, n_out_status;

    logic               w_leap;
    logic [DAY_W-1:0]   w_mlen_in;
    logic [DAY_W-1:0]   w_mlen_res;
    logic [ACC_W-1:0]   w_sub;
    logic [ACC_W:0]     w_trial;
    logic               w_fits;
    logic [15:0]        w_q4_days;
    logic [10:0]        w_q1_days;
    logic [N_W-1:0]     w_off_ext;

    // leap flag and month lengths from the current digits
    assign w_leap     = leap_from_digits(r_q100, r_q4, r_q1);
    assign w_mlen_in  = month_len(r_month, w_leap);
    assign w_mlen_res = month_len(r_rm, w_leap);

    // trial subtract for the restoring digit steps and the month walk
    always_comb begin
        unique case (i_cmd.op)
            DP_F400: w_sub = C_YRS_400  << i_cmd.k;
            DP_F100: w_sub = C_YRS_100  << i_cmd.k;
            DP_B400: w_sub = C_DAYS_400 << i_cmd.k;
            DP_B100: w_sub = C_DAYS_100 << i_cmd.k;
            DP_B4:   w_sub = C_DAYS_4   << i_cmd.k;
            DP_B1:   w_sub = C_DAYS_1   << i_cmd.k;
            DP_MONTH: w_sub = ACC_W'(w_mlen_res);
            default: w_sub = '0;
        endcase
    end

    assign w_trial   = {1'b0, r_acc} - {1'b0, w_sub};
    assign w_fits    = !w_trial[ACC_W];
    assign w_q4_days = 16'(r_acc[6:2]) * 16'd1461;
    assign w_q1_days = 11'(r_acc[1:0]) * 11'd365;
    assign w_off_ext = {{(N_W-OFF_W){r_off[OFF_W-1]}}, r_off};

    // status to the controller
    assign o_stat.basic_bad  = (r_year == '0) || (r_year > YEAR_MAX) ||
                               (r_month == '0) || (r_month > MONTH_MAX) ||
                               (r_day == '0);
    assign o_stat.day_bad    = (r_day > w_mlen_in);
    assign o_stat.range_bad  = r_n[N_W-1] || (r_n >= DAYS_LIMIT);
    assign o_stat.month_done = (r_rm == MONTH_MAX) || (r_acc < ACC_W'(w_mlen_res));

    // next values per operation
    always_comb begin
        n_acc        = r_acc;
        n_n          = r_n;
        n_q100       = r_q100;
        n_q4         = r_q4;
        n_q1         = r_q1;
        n_ry         = r_ry;
        n_rm         = r_rm;
        n_valid      = 1'b0;
        n_out_year   = r_out_year;
        n_out_month  = r_out_month;
        n_out_day    = r_out_day;
        n_out_status = r_out_status;
        unique case (i_cmd.op)
            DP_LOAD: begin
                n_acc  = ACC_W'(i_in_year) - ACC_W'(1);
                n_n    = '0;
                n_q100 = '0;
                n_q4   = '0;
                n_q1   = '0;
            end
            DP_F400: begin
                if (w_fits) begin
                    n_acc = w_trial[ACC_W-1:0];
                    n_n   = r_n + (N_W'(C_DAYS_400) << i_cmd.k);
                end
            end
            DP_F100: begin
                if (w_fits) begin
                    n_acc             = w_trial[ACC_W-1:0];
                    n_n               = r_n + (N_W'(C_DAYS_100) << i_cmd.k);
                    n_q100[i_cmd.k[0]] = 1'b1;
                end
            end
            DP_FREM: begin
                n_q4 = r_acc[6:2];
                n_q1 = r_acc[1:0];
                n_n  = r_n + N_W'(w_q4_days) + N_W'(w_q1_days);
            end
            DP_SUM: begin
                n_n = r_n + N_W'(days_before_month(r_month))
                    + N_W'(w_leap && (r_month > MONTH_W'(2)))
                    + N_W'(r_day) - N_W'(1) + w_off_ext;
            end
            DP_BLOAD: begin
                n_acc  = r_n[ACC_W-1:0];
                n_ry   = C_Y1;
                n_rm   = MONTH_W'(1);
                n_q100 = '0;
                n_q4   = '0;
                n_q1   = '0;
            end
            DP_B400: begin
                if (w_fits) begin
                    n_acc = w_trial[ACC_W-1:0];
                    n_ry  = r_ry + (C_Y400 << i_cmd.k);
                end
            end
            DP_B100: begin
                if (w_fits) begin
                    n_acc              = w_trial[ACC_W-1:0];
                    n_ry               = r_ry + (C_Y100 << i_cmd.k);
                    n_q100[i_cmd.k[0]] = 1'b1;
                end
            end
            DP_B4: begin
                if (w_fits) begin
                    n_acc          = w_trial[ACC_W-1:0];
                    n_ry           = r_ry + (C_Y4 << i_cmd.k);
                    n_q4[i_cmd.k]  = 1'b1;
                end
            end
            DP_B1: begin
                if (w_fits) begin
                    n_acc            = w_trial[ACC_W-1:0];
                    n_ry             = r_ry + (C_Y1 << i_cmd.k);
                    n_q1[i_cmd.k[0]] = 1'b1;
                end
            end
            DP_MONTH: begin
                n_acc = w_trial[ACC_W-1:0];
                n_rm  = r_rm + MONTH_W'(1);
            end
            DP_FINISH: begin
                n_valid      = 1'b1;
                n_out_status = i_cmd.status;
                if (i_cmd.status == ST_OK) begin
                    n_out_year  = r_ry;
                    n_out_month = r_rm;
                    n_out_day   = r_acc[DAY_W-1:0] + DAY_W'(1);
                end else begin
                    n_out_year  = r_year;
                    n_out_month = r_month;
                    n_out_day   = r_day;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // request capture, working registers and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_LOAD) begin
            r_year  <= i_in_year;
            r_month <= i_in_month;
            r_day   <= i_in_day;
            r_off   <= i_day_offset;
        end
        r_acc        <= n_acc;
        r_n          <= n_n;
        r_q100       <= n_q100;
        r_q4         <= n_q4;
        r_q1         <= n_q1;
        r_ry         <= n_ry;
        r_rm         <= n_rm;
        r_out_year   <= n_out_year;
        r_out_month  <= n_out_month;
        r_out_day    <= n_out_day;
        r_out_status <= n_out_status;
    end

    assign o_valid     = r_valid;
    assign o_out_year  = r_out_year;
    assign o_out_month = r_out_month;
    assign o_out_day   = r_out_day;
    assign o_status    = r_out_status;

endmodule

[src/date_add_days_core.sv]
// ----------------------------------------------------------------------------
// date_add_days_core: Gregorian date plus signed day offset
// o_valid rises after the field check for a request with a malformed field,
// after the day check for a bad day, after the range check for an
// out-of-range result, and after the digit steps and month walk for a good one.
// A new request is taken in the strobe cycle; while busy, start is ignored.
// Synchronous active-low reset returns the sequencer to idle, no strobe.
// ----------------------------------------------------------------------------
module date_add_days_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dad_pkg::YEAR_W-1:0]   i_in_year,
    input  logic [dad_pkg::MONTH_W-1:0]  i_in_month,
    input  logic [dad_pkg::DAY_W-1:0]    i_in_day,
    input  logic [dad_pkg::OFF_W-1:0]    i_day_offset,
    output logic                         o_valid,
    output logic [dad_pkg::YEAR_W-1:0]   o_out_year,
    output logic [dad_pkg::MONTH_W-1:0]  o_out_month,
    output logic [dad_pkg::DAY_W-1:0]    o_out_day,
    output logic [dad_pkg::STAT_W-1:0]   o_status
);
    import dad_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    dad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // arithmetic and result registers
    dad_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_year    (i_in_year),
        .i_in_month   (i_in_month),
        .i_in_day     (i_in_day),
        .i_day_offset (i_day_offset),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .o_out_year   (o_out_year),
        .o_out_month  (o_out_month),
        .o_out_day    (o_out_day),
        .o_status     (o_status)
    );

endmodule
